// ===== sv/bssfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bssfr_pkg
// Shared types and constants of the bit-slip sync frame receiver.
// ----------------------------------------------------------------------------
package bssfr_pkg;

   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_RECV   = 2'd1;
   localparam logic [1:0] MODE_HOLD   = 2'd2;

   localparam logic [7:0] HDR_BYTES        = 8'd2;
   localparam logic [7:0] MAX_LEN_DEFAULT  = 8'd130;
   localparam int unsigned NUM_PAT         = 8;

   // sync patterns per bit offset: preamble and sync in four history bytes
   localparam logic [15:0] PAT_HI [NUM_PAT] = '{
      16'hAAD3, 16'h5569, 16'hAAB4, 16'h555A,
      16'hAAAD, 16'h5556, 16'hAAAB, 16'h5555
   };
   localparam logic [15:0] PAT_LO [NUM_PAT] = '{
      16'h0091, 16'hC880, 16'hE440, 16'h7220,
      16'h3910, 16'h9C88, 16'h4E44, 16'hA722
   };
   localparam logic [2:0] PAT_CODE [NUM_PAT] = '{
      3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1
   };

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic              [7:0] data_byte;
      logic              [7:0] byte_index;
      logic                    frame_done;
      logic                    frame_abort;
      logic signed       [2:0] bit_offset;
   } result_type;

endpackage

// ===== sv/bssfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// bssfr_in_stage
// Input register of the request channel; issues one request per cycle while the result register is free.
// ----------------------------------------------------------------------------
module bssfr_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bssfr_pkg::item_type req_item,
   input  logic                out_free,
   output logic                fire,
   output bssfr_pkg::item_type item
);

   logic                vld_ff;
   logic                vld_in;
   bssfr_pkg::item_type item_ff;

   assign fire       = vld_ff && out_free;
   assign req_tready = !vld_ff || out_free;
   assign vld_in     = req_tready ? req_tvalid : vld_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== sv/bssfr_core.sv =====
// ----------------------------------------------------------------------------
// bssfr_core
// Sync search, bit realignment and frame length tracking, one request a cycle while the output stage is free.
// ----------------------------------------------------------------------------
module bssfr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  fire,
   input  bssfr_pkg::item_type   item,
   output logic                  res_vld,
   output bssfr_pkg::result_type res
);

   logic [31:0] hist_ff,  hist_in;
   logic [1:0]  mode_ff,  mode_in;
   logic [2:0]  shift_ff, shift_in;
   logic [7:0]  cnt_ff,   cnt_in;
   logic [7:0]  flen_ff,  flen_in;
   logic [7:0]  max_len_ff;

   logic [31:0] hist_new;
   logic        found;
   logic [2:0]  found_code;
   logic [15:0] pair;
   logic [15:0] sh;
   logic [2:0]  lshift;
   logic        emit;
   logic [7:0]  emit_data;
   logic [7:0]  start_cnt;
   logic [7:0]  inc_cnt;

   assign hist_new = {hist_ff[23:0], item.rx_byte};
   assign pair     = {hist_ff[7:0], item.rx_byte};
   assign lshift   = 3'(4'd8 - {1'b0, shift_ff});
   assign sh       = shift_ff[2] ? 16'(pair << lshift) : (pair >> shift_ff);

   always_comb begin
      found      = 1'b0;
      found_code = bssfr_pkg::PAT_CODE[0];
      for (int k = 1; k < bssfr_pkg::NUM_PAT; k++) begin
         if (!found && hist_new == {bssfr_pkg::PAT_HI[k], bssfr_pkg::PAT_LO[k]}) begin
            found      = 1'b1;
            found_code = bssfr_pkg::PAT_CODE[k];
         end
      end
   end

   always_comb begin
      hist_in   = hist_ff;
      mode_in   = mode_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      flen_in   = flen_ff;
      emit      = 1'b0;
      emit_data = item.rx_byte;
      start_cnt = cnt_ff;
      res_vld   = 1'b0;
      res       = '0;

      if (item.cmd) begin
         mode_in = bssfr_pkg::MODE_SEARCH;
         cnt_in  = '0;
      end else begin
         unique case (mode_ff)
            bssfr_pkg::MODE_SEARCH: begin
               hist_in = hist_new;
               if (hist_new[31:16] == bssfr_pkg::PAT_HI[0]
                   && hist_new[15:8] == bssfr_pkg::PAT_LO[0][7:0]) begin
                  shift_in  = bssfr_pkg::PAT_CODE[0];
                  mode_in   = bssfr_pkg::MODE_RECV;
                  emit      = 1'b1;
                  start_cnt = '0;
               end else if (found) begin
                  shift_in = found_code;
                  mode_in  = bssfr_pkg::MODE_RECV;
                  cnt_in   = '0;
               end
            end
            bssfr_pkg::MODE_RECV: begin
               emit = 1'b1;
               if (shift_ff != 3'd0) begin
                  emit_data = shift_ff[2] ? sh[15:8] : sh[7:0];
                  hist_in   = {sh, pair};
               end
            end
            default: begin
            end
         endcase
      end

      inc_cnt = start_cnt + 8'd1;
      if (emit) begin
         res_vld          = 1'b1;
         res.data_byte    = emit_data;
         res.byte_index   = start_cnt;
         res.bit_offset   = shift_in;
         cnt_in           = inc_cnt;
         if (inc_cnt == bssfr_pkg::HDR_BYTES) begin
            flen_in = emit_data;
            if (emit_data <= bssfr_pkg::HDR_BYTES || emit_data > max_len_ff) begin
               res.frame_abort = 1'b1;
               cnt_in          = '0;
               mode_in         = bssfr_pkg::MODE_SEARCH;
            end
         end else if (inc_cnt > bssfr_pkg::HDR_BYTES && inc_cnt == flen_ff) begin
            res.frame_done = 1'b1;
            mode_in        = bssfr_pkg::MODE_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         mode_ff    <= bssfr_pkg::MODE_SEARCH;
         shift_ff   <= '0;
         cnt_ff     <= '0;
         flen_ff    <= '0;
         max_len_ff <= bssfr_pkg::MAX_LEN_DEFAULT;
      end else begin
         if (fire) begin
            hist_ff  <= hist_in;
            mode_ff  <= mode_in;
            shift_ff <= shift_in;
            cnt_ff   <= cnt_in;
            flen_ff  <= flen_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== sv/bssfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// bssfr_out_stage
// Result register of the response channel.
// ----------------------------------------------------------------------------
module bssfr_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  res_vld,
   input  bssfr_pkg::result_type res,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output bssfr_pkg::result_type rsp_res
);

   logic                  vld_ff;
   logic                  vld_in;
   bssfr_pkg::result_type res_ff;

   assign out_free   = !vld_ff || rsp_tready;
   assign vld_in     = fire ? res_vld : (vld_ff && !rsp_tready);
   assign rsp_tvalid = vld_ff;
   assign rsp_res    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_vld) begin
         res_ff <= res;
      end
   end

endmodule

// ===== sv/bit_slip_sync_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// bit_slip_sync_frame_receiver_unit
// Finds preamble and sync at any bit offset and emits the realigned frame.
// ----------------------------------------------------------------------------
// Takes one request per clock while no response waits. A request is held in
// the input register after acceptance; its response is valid on the port once
// it has passed the core logic and the result register has loaded.
// The rate is one byte per cycle when no response waits, set by the single pass
// of search, realign and length check logic between the two registers. A
// waiting response holds back the request in the input register, including one
// that gives no response (search, hold, restart), so the input stalls once the
// input register is full. Length checks use csr max_frame_len (reset 130), which
// the user must write only when idle; the block itself does not enforce this.
module bit_slip_sync_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // max_frame_len
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte
   input  logic        req_tuser,     // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [7:0] data_byte, [15:8] byte_index,
                                      // [18:16] bit_offset, [23:19] zero
   output logic        rsp_tlast,     // frame_done
   output logic        rsp_tuser      // [0] frame_abort
);

   bssfr_pkg::item_type   req_item;
   bssfr_pkg::item_type   item;
   bssfr_pkg::result_type res;
   bssfr_pkg::result_type rsp_res;
   logic                  out_free;
   logic                  fire;
   logic                  res_vld;

   assign req_item.cmd     = req_tuser;
   assign req_item.rx_byte = req_tdata;

   bssfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_free   (out_free),
      .fire       (fire),
      .item       (item)
   );

   bssfr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .res_vld     (res_vld),
      .res         (res)
   );

   bssfr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_vld    (res_vld),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {5'd0, rsp_res.bit_offset, rsp_res.byte_index, rsp_res.data_byte};
   assign rsp_tlast = rsp_res.frame_done;
   assign rsp_tuser = rsp_res.frame_abort;

endmodule

// ===== sv/bssfr_checker.sv =====
// ----------------------------------------------------------------------------
// bssfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module bssfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   a_done_abort_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tlast && rsp_tuser))
      else $error("frame done and abort on the same byte");

   a_abort_on_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:8] == 8'd1)
      else $error("abort not on length byte");

   a_done_after_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[15:8] >= 8'd2)
      else $error("frame done inside header");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind bit_slip_sync_frame_receiver_unit bssfr_checker u_bssfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/tb_bit_slip_sync_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bit_slip_sync_frame_receiver_unit
// Self-checking bench for the bit-slip sync frame receiver.
// ----------------------------------------------------------------------------
// Builds serial streams of preamble, sync word and frame at every bit offset,
// mixed with bad lengths, cut frames, restarts and noise, and checks each
// response against an in-bench model of the search, realign and length logic.
// Random stalls on both sides, one long response hold-off, and max_frame_len
// swept over several settings between phases.
// ----------------------------------------------------------------------------
module tb_bit_slip_sync_frame_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 180;
   localparam int NUM_PHASES     = 7;

   localparam logic       CMD_BYTE    = 1'b0;
   localparam logic       CMD_RESTART = 1'b1;
   localparam logic [7:0] PREAMBLE    = 8'hAA;
   localparam logic [7:0] SYNC_0      = 8'hD3;
   localparam logic [7:0] SYNC_1      = 8'h91;
   localparam logic [2:0] SHIFT_NONE  = 3'd0;
   localparam logic [2:0] SHIFT_LEFT  = 3'd4;

   // history patterns for a stream delayed by 0..7 bits
   localparam logic [15:0] SYNC_HI [8] = '{
      16'hAAD3, 16'h5569, 16'hAAB4, 16'h555A,
      16'hAAAD, 16'h5556, 16'hAAAB, 16'h5555
   };
   localparam logic [15:0] SYNC_LO [8] = '{
      16'h0091, 16'hC880, 16'hE440, 16'h7220,
      16'h3910, 16'h9C88, 16'h4E44, 16'hA722
   };
   localparam logic [2:0] SYNC_CODE [8] = '{
      3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   bssfr_pkg::item_type   req_pending_q [$];
   bssfr_pkg::result_type rsp_expected_q [$];

   int  reqs_queued   = 0;
   int  reqs_accepted = 0;
   int  mismatches    = 0;
   int  quiet_cycles  = 0;
   int  src_wait      = 0;
   int  sink_wait     = 0;
   int  cur_max_len   = bssfr_pkg::MAX_LEN_DEFAULT;
   bit  req_taken     = 1'b0;
   bit  src_idle_on   = 1'b1;
   bit  sink_idle_on  = 1'b1;
   bit  long_hold_req = 1'b0;
   bit  hold_seen     = 1'b0;

   // receiver model state
   logic [31:0] rx_history;
   logic [1:0]  rx_mode;
   logic [2:0]  rx_shift;
   logic [7:0]  rx_count;
   logic [7:0]  rx_len;
   logic [7:0]  rx_max_len;

   bit_slip_sync_frame_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic void count_frame_byte(input logic [7:0] data);
      bssfr_pkg::result_type r;
      r.data_byte   = data;
      r.byte_index  = rx_count;
      r.frame_done  = 1'b0;
      r.frame_abort = 1'b0;
      r.bit_offset  = rx_shift;
      rx_count      = rx_count + 8'd1;
      if (rx_count == bssfr_pkg::HDR_BYTES) begin
         rx_len = data;
         if (data <= bssfr_pkg::HDR_BYTES || data > rx_max_len) begin
            r.frame_abort = 1'b1;
            rx_count      = 8'd0;
            rx_mode       = bssfr_pkg::MODE_SEARCH;
         end
      end else if (rx_count > bssfr_pkg::HDR_BYTES && rx_count == rx_len) begin
         r.frame_done = 1'b1;
         rx_mode      = bssfr_pkg::MODE_HOLD;
      end
      rsp_expected_q.push_back(r);
   endfunction

   function automatic void predict_request(input bssfr_pkg::item_type it);
      logic [15:0] pair;
      logic [15:0] sh;
      logic [7:0]  data;
      bit          found;
      if (it.cmd == CMD_RESTART) begin
         rx_mode  = bssfr_pkg::MODE_SEARCH;
         rx_count = 8'd0;
      end else if (rx_mode == bssfr_pkg::MODE_SEARCH) begin
         rx_history = {rx_history[23:0], it.rx_byte};
         if (rx_history[31:16] == SYNC_HI[0] && rx_history[15:8] == SYNC_LO[0][7:0]) begin
            // aligned sync: the byte after it is already frame byte 0
            rx_shift = SYNC_CODE[0];
            rx_mode  = bssfr_pkg::MODE_RECV;
            rx_count = 8'd0;
            count_frame_byte(it.rx_byte);
         end else begin
            found = 1'b0;
            for (int k = 1; k < 8; k++) begin
               if (!found && rx_history[31:16] == SYNC_HI[k]
                   && rx_history[15:0] == SYNC_LO[k]) begin
                  found    = 1'b1;
                  rx_shift = SYNC_CODE[k];
                  rx_mode  = bssfr_pkg::MODE_RECV;
                  rx_count = 8'd0;
               end
            end
         end
      end else if (rx_mode == bssfr_pkg::MODE_RECV) begin
         if (rx_shift == SHIFT_NONE) begin
            data = it.rx_byte;
         end else begin
            pair = {rx_history[7:0], it.rx_byte};
            if (rx_shift >= SHIFT_LEFT) begin
               sh   = pair << (4'd8 - rx_shift);
               data = sh[15:8];
            end else begin
               sh   = pair >> rx_shift;
               data = sh[7:0];
            end
            rx_history = {sh, pair};
         end
         count_frame_byte(data);
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void push_item(input logic cmd, input logic [7:0] b);
      bssfr_pkg::item_type it;
      it.cmd     = cmd;
      it.rx_byte = b;
      req_pending_q.push_back(it);
      reqs_queued++;
   endfunction

   // preamble, sync and frame bytes, delayed by k bits, plus one trailing byte
   function automatic void send_frame(input int k, input logic [7:0] f0,
                                      input logic [7:0] len_b, input int nbytes);
      logic [7:0]  raw [$];
      logic [7:0]  prev;
      logic [15:0] pair;
      raw = '{PREAMBLE, PREAMBLE, PREAMBLE, SYNC_0, SYNC_1};
      for (int i = 0; i < nbytes; i++) begin
         raw.push_back(i == 0 ? f0 : (i == 1 ? len_b : 8'($urandom)));
      end
      raw.push_back(8'($urandom));
      prev = PREAMBLE;
      foreach (raw[i]) begin
         pair = {prev, raw[i]};
         push_item(CMD_BYTE, 8'(pair >> k));
         prev = raw[i];
      end
   endfunction

   // off-zero sync also matches on the top bits of frame byte 0
   function automatic logic [7:0] first_byte(input int k);
      if (k == 0) begin
         return 8'($urandom);
      end
      return 8'($urandom) & 8'((1 << k) - 1);
   endfunction

   function automatic void random_phase(input int n_items);
      int stop_at;
      int k;
      int kind;
      int len;
      int cap;
      stop_at = reqs_queued + n_items;
      cap     = (cur_max_len < 24) ? cur_max_len : 24;
      while (reqs_queued < stop_at) begin
         k    = $urandom_range(0, 7);
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            if ($urandom_range(0, 19) == 0) begin
               len = $urandom_range(3, cur_max_len);
            end else begin
               len = $urandom_range(3, cap);
            end
            send_frame(k, first_byte(k), 8'(len), len);
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 3)) push_item(CMD_BYTE, 8'($urandom));
            end
            push_item(CMD_RESTART, 8'($urandom));
         end else if (kind < 82) begin
            if (cur_max_len < 255 && $urandom_range(0, 1) == 0) begin
               len = $urandom_range(cur_max_len + 1, 255);
            end else begin
               len = $urandom_range(0, 2);
            end
            send_frame(k, first_byte(k), 8'(len), 2);
         end else if (kind < 90) begin
            len = $urandom_range(3, cap);
            send_frame(k, first_byte(k), 8'(len), $urandom_range(1, len - 1));
            push_item(CMD_RESTART, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               push_item(($urandom_range(0, 7) == 0) ? CMD_RESTART : CMD_BYTE,
                         8'($urandom));
            end
         end
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (reqs_accepted != reqs_queued || rsp_expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_max_len = v;
   endtask

   always @(negedge clock) begin : req_source
      bssfr_pkg::item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (src_wait > 0) begin
            src_wait--;
            req_tvalid <= 1'b0;
         end else if (req_pending_q.size() != 0) begin
            nxt = req_pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.rx_byte;
            req_tuser  <= nxt.cmd;
            if (src_idle_on && $urandom_range(0, 99) < 20) begin
               src_wait = gap_len();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_sink
      if (hold_seen != long_hold_req) begin
         hold_seen = long_hold_req;
         sink_wait = LONG_HOLD;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 99) < 15) begin
         sink_wait = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bssfr_pkg::result_type want;
      bssfr_pkg::item_type   got_req;
      if (reset) begin
         rx_history   = 32'd0;
         rx_mode      = bssfr_pkg::MODE_SEARCH;
         rx_shift     = SHIFT_NONE;
         rx_count     = 8'd0;
         rx_len       = 8'd0;
         rx_max_len   = bssfr_pkg::MAX_LEN_DEFAULT;
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            rx_max_len = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected_q.size() == 0) begin
               $display("%0t: response with none expected, tdata %06h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = rsp_expected_q.pop_front();
               check_field("data_byte", want.data_byte, rsp_tdata[7:0]);
               check_field("byte_index", want.byte_index, rsp_tdata[15:8]);
               check_field("bit_offset", unsigned'(want.bit_offset), rsp_tdata[18:16]);
               check_field("frame_done", want.frame_done, rsp_tlast);
               check_field("frame_abort", want.frame_abort, rsp_tuser);
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            got_req.cmd     = req_tuser;
            got_req.rx_byte = req_tdata;
            predict_request(got_req);
            reqs_accepted++;
         end
         if (req_taken || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int phase_max [NUM_PHASES];
      phase_max = '{3, 255, 130, 0, 0, 16, 255};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, aligned frame with hold and restart,
      // far-left offset with a zero length
      push_item(CMD_BYTE, 8'h00);
      push_item(CMD_BYTE, 8'hFF);
      send_frame(0, 8'hFF, 8'd3, 3);
      push_item(CMD_RESTART, 8'h00);
      send_frame(4, 8'h0F, 8'd0, 2);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (phase_max[p] == 0) begin
            phase_max[p] = $urandom_range(3, 255);
         end
         write_max_len(8'(phase_max[p]));
         src_idle_on  = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         @(posedge clock);
         if (p == 1) begin
            // long frame against a held-off response sink to back up the input
            send_frame(2, first_byte(2), 8'd120, 120);
            push_item(CMD_RESTART, 8'($urandom));
            long_hold_req = ~long_hold_req;
         end
         random_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (mismatches == 0 && rsp_expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
